FILE: rtl/assert_macros.svh
// Assertion helpers used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/gplc_pkg.sv
package gplc_pkg;

    localparam int unsigned QUOT_WIDTH = 32;

    typedef enum logic [1:0] {
        MODE_POSITIVE = 2'd0,
        MODE_NEGATIVE = 2'd1,
        MODE_BIDIR    = 2'd2,
        MODE_SPARE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE           = 3'd0,
        REG_POINT_ONE      = 3'd1,
        REG_POINT_TWO      = 3'd2,
        REG_POINT_THREE    = 3'd3,
        REG_POINT_FOUR     = 3'd4,
        REG_ZERO_THRESHOLD = 3'd5,
        REG_FULL_SCALE     = 3'd6
    } reg_index_t;

    // Control word that travels with a sample through the divider cells.
    typedef struct packed {
        logic        valid;
        logic        direct;    // result is a stored value, no division
        logic        zero_div;
        logic [15:0] base;
        logic [15:0] full_scale;
    } cell_ctl_t;

endpackage

FILE: rtl/gplc_setup.sv
// First stage: pick the segment, form the 32-bit product and divisor.
module gplc_setup #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned VALUE_WIDTH  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [15:0]              sample_adc,
    input  logic [1:0]               mode,
    input  logic [31:0]              point_one,
    input  logic [31:0]              point_two,
    input  logic [31:0]              point_three,
    input  logic [31:0]              point_four,
    input  logic [15:0]              zero_threshold,
    input  logic [15:0]              full_scale,
    output gplc_pkg::cell_ctl_t      ctl,
    output logic [31:0]              dividend,
    output logic [31:0]              divisor
);
    import gplc_pkg::*;

    logic [31:0] adc, a1, a2, a3, a4, v1, v2, v3, v4;
    logic [31:0] d, vd, offset, ad, base;
    logic        direct;
    logic [31:0] res_direct;
    logic [31:0] prod;
    cell_ctl_t   ctl_next, ctl_reg;
    logic [31:0] dividend_reg, divisor_reg;

    assign adc = {{(32-SAMPLE_WIDTH){1'b0}}, sample_adc[SAMPLE_WIDTH-1:0]};
    assign a1 = {{(32-SAMPLE_WIDTH){1'b0}}, point_one[16 +: SAMPLE_WIDTH]};
    assign a2 = {{(32-SAMPLE_WIDTH){1'b0}}, point_two[16 +: SAMPLE_WIDTH]};
    assign a3 = {{(32-SAMPLE_WIDTH){1'b0}}, point_three[16 +: SAMPLE_WIDTH]};
    assign a4 = {{(32-SAMPLE_WIDTH){1'b0}}, point_four[16 +: SAMPLE_WIDTH]};
    assign v1 = {{(32-VALUE_WIDTH){1'b0}}, point_one[VALUE_WIDTH-1:0]};
    assign v2 = {{(32-VALUE_WIDTH){1'b0}}, point_two[VALUE_WIDTH-1:0]};
    assign v3 = {{(32-VALUE_WIDTH){1'b0}}, point_three[VALUE_WIDTH-1:0]};
    assign v4 = {{(32-VALUE_WIDTH){1'b0}}, point_four[VALUE_WIDTH-1:0]};

    always_comb
    begin
        direct     = 1'b0;
        res_direct = v1;
        vd     = v3 - v1;
        offset = adc - a1;
        ad     = a3 - a1;
        base   = v1;
        d      = 32'd0;
        if (mode == MODE_NEGATIVE)
        begin
            d = (adc < a3) ? (a3 - adc) : 32'd0;
            vd     = v1 - v3;
            offset = d;
            base   = v3;
            if (d <= {16'd0, zero_threshold})
            begin
                direct     = 1'b1;
                res_direct = v3;
            end
        end
        else
        begin
            d = (adc > a1) ? (adc - a1) : 32'd0;
            if (d <= {16'd0, zero_threshold})
            begin
                direct = 1'b1;
            end
            else if (mode == MODE_POSITIVE)
            begin
                offset = d;
            end
            else if (adc < a3)
            begin
                if (a2 > a1 && a2 < a3)
                begin
                    if (adc < a2)
                    begin
                        vd = v2 - v1;
                        ad = a2 - a1;
                    end
                    else if (adc > a2)
                    begin
                        vd     = v3 - v2;
                        offset = adc - a2;
                        ad     = a3 - a2;
                        base   = v2;
                    end
                    else
                    begin
                        direct     = 1'b1;
                        res_direct = v2;
                    end
                end
            end
            else if (adc > a3)
            begin
                if (a4 > a3)
                begin
                    if (adc < a4)
                    begin
                        vd     = v4 - v3;
                        offset = adc - a3;
                        ad     = a4 - a3;
                        base   = v3;
                    end
                    else if (adc > a4)
                    begin
                        vd = v4 - v1;
                        ad = a4 - a1;
                    end
                    else
                    begin
                        direct     = 1'b1;
                        res_direct = v4;
                    end
                end
            end
            else
            begin
                direct     = 1'b1;
                res_direct = v3;
            end
        end
        prod = vd * offset;
        ctl_next.valid      = in_valid;
        ctl_next.direct     = direct;
        ctl_next.zero_div   = !direct && (ad == 32'd0);
        ctl_next.base       = direct ? res_direct[15:0] : base[15:0];
        ctl_next.full_scale = full_scale;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= prod;
        divisor_reg  <= ad;
    end

    assign ctl      = ctl_reg;
    assign dividend = dividend_reg;
    assign divisor  = divisor_reg;
endmodule

FILE: rtl/gplc_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes on.
module gplc_div_cell #(
    parameter int unsigned BIT_POS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gplc_pkg::cell_ctl_t ctl_in,
    input  logic [31:0]         rem_in,
    input  logic [31:0]         num_in,
    input  logic [31:0]         quot_in,
    input  logic [31:0]         divisor_in,
    output gplc_pkg::cell_ctl_t ctl_out,
    output logic [31:0]         rem_out,
    output logic [31:0]         num_out,
    output logic [31:0]         quot_out,
    output logic [31:0]         divisor_out
);
    import gplc_pkg::*;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;
    cell_ctl_t   ctl_reg;
    logic [31:0] rem_reg, num_reg, quot_reg, divisor_reg;

    assign trial = {rem_in, num_in[BIT_POS]};
    assign diff  = trial - {1'b0, divisor_in};
    assign fits  = !diff[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= fits ? diff[31:0] : trial[31:0];
        num_reg     <= num_in;
        quot_reg    <= {quot_in[30:0], fits};
        divisor_reg <= divisor_in;
    end

    assign ctl_out     = ctl_reg;
    assign rem_out     = rem_reg;
    assign num_out     = num_reg;
    assign quot_out    = quot_reg;
    assign divisor_out = divisor_reg;
endmodule

FILE: rtl/gplc_finish.sv
// Last stage: add base (or pass a direct value), cut to value width, clamp to full scale.
module gplc_finish #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gplc_pkg::cell_ctl_t ctl,
    input  logic [31:0]         quot,
    output logic                done,
    output logic [15:0]         concentration
);
    import gplc_pkg::*;

    logic [31:0] sum;
    logic [15:0] res;
    logic [15:0] res_next;
    logic        done_reg;
    logic [15:0] conc_reg;

    always_comb
    begin
        sum = quot + {16'd0, ctl.base};
        res = {{(16-VALUE_WIDTH){1'b0}}, sum[VALUE_WIDTH-1:0]};
        if (ctl.direct)
        begin
            res = ctl.base;
        end
        if (ctl.zero_div || res > ctl.full_scale)
        begin
            res_next = ctl.full_scale;
        end
        else
        begin
            res_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        conc_reg <= res_next;
    end

    assign done          = done_reg;
    assign concentration = conc_reg;
endmodule

FILE: rtl/gas_piecewise_linear_calibration_core.sv
// Each sample passes from start to done through setup, 32 divider cells and finish.
// Throughput: one sample per cycle; busy is always low, samples enter back to back.
// The row of 32 divider cells, one quotient bit each, sets the latency.
// Reset returns the configuration registers to their defaults (full scale all ones,
// the rest zero) and clears the valid flags of every stage.
// The receiver cannot stall: each result is shown with done for one cycle.
module gas_piecewise_linear_calibration_core #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned VALUE_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] sample_adc,
    output logic        done,
    output logic [15:0] concentration,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import gplc_pkg::*;

    logic [1:0]  mode_reg;
    logic [31:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [15:0] zt_reg, fs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_POSITIVE;
            p1_reg   <= '0;
            p2_reg   <= '0;
            p3_reg   <= '0;
            p4_reg   <= '0;
            zt_reg   <= '0;
            fs_reg   <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:           mode_reg <= cfg_data[1:0];
                REG_POINT_ONE:      p1_reg   <= cfg_data;
                REG_POINT_TWO:      p2_reg   <= cfg_data;
                REG_POINT_THREE:    p3_reg   <= cfg_data;
                REG_POINT_FOUR:     p4_reg   <= cfg_data;
                REG_ZERO_THRESHOLD: zt_reg   <= cfg_data[15:0];
                REG_FULL_SCALE:     fs_reg   <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    assign busy = 1'b0;

    cell_ctl_t   ctl_c  [QUOT_WIDTH+1];
    logic [31:0] rem_c  [QUOT_WIDTH+1];
    logic [31:0] num_c  [QUOT_WIDTH+1];
    logic [31:0] quot_c [QUOT_WIDTH+1];
    logic [31:0] div_c  [QUOT_WIDTH+1];

    gplc_setup #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_setup (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start && !busy),
        .sample_adc    (sample_adc),
        .mode          (mode_reg),
        .point_one     (p1_reg),
        .point_two     (p2_reg),
        .point_three   (p3_reg),
        .point_four    (p4_reg),
        .zero_threshold(zt_reg),
        .full_scale    (fs_reg),
        .ctl           (ctl_c[0]),
        .dividend      (num_c[0]),
        .divisor       (div_c[0])
    );

    assign rem_c[0]  = '0;
    assign quot_c[0] = '0;

    for (genvar i = 0; i < QUOT_WIDTH; i++)
    begin : g_cell
        gplc_div_cell #(
            .BIT_POS(QUOT_WIDTH - 1 - i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (ctl_c[i]),
            .rem_in     (rem_c[i]),
            .num_in     (num_c[i]),
            .quot_in    (quot_c[i]),
            .divisor_in (div_c[i]),
            .ctl_out    (ctl_c[i+1]),
            .rem_out    (rem_c[i+1]),
            .num_out    (num_c[i+1]),
            .quot_out   (quot_c[i+1]),
            .divisor_out(div_c[i+1])
        );
    end

    gplc_finish #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_c[QUOT_WIDTH]),
        .quot         (quot_c[QUOT_WIDTH]),
        .done         (done),
        .concentration(concentration)
    );

`include "assert_macros.svh"

    `ASSERT_NOW(a_never_busy, clk, rst_n, 1'b1, !busy)
    `ASSERT_NEXT(a_done_follows, clk, rst_n, ctl_c[QUOT_WIDTH].valid, done)
    `ASSERT_NOW(a_clamped, clk, rst_n, done, concentration <= $past(fs_reg))
    `ASSERT_NEXT(a_pipe_step, clk, rst_n, start, ctl_c[0].valid)
endmodule
